// ----- design/fltm_pkg.sv -----
`default_nettype none

package fltm_pkg;

   // Table store geometry.
   localparam int TABLE_COUNT       = 64;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int TBL_W             = $clog2(TABLE_COUNT);
   localparam int NF_W              = $clog2(TABLE_COUNT + 1);
   localparam int ADDR_W            = TBL_W + IDX_W;
   localparam int DEPTH             = TABLE_COUNT * ENTRIES_PER_TABLE;

   // Field widths.
   localparam int VP_W     = 36;
   localparam int PAGE_W   = 40;
   localparam int ENTRY_W  = 43;
   localparam int STATUS_W = 2;
   localparam int LVL_W    = 2;

   // Entry flag positions.
   localparam int BIT_PRESENT = 40;
   localparam int BIT_WRITE   = 41;
   localparam int BIT_USER    = 42;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_MAPPED = 2'd1,
      STATUS_NO_TABLES  = 2'd2
   } status_type;

   typedef enum logic {
      REQ_MAP    = 1'b0,
      REQ_LOOKUP = 1'b1
   } req_kind_type;

   typedef enum logic [1:0] {
      SRC_ZERO,
      SRC_READ,
      SRC_LEAF
   } res_src_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_ALLOC,
      ST_LEAF,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        clear_wr;
      logic        capture;
      logic        rd_issue;
      logic        follow;
      logic        alloc;
      logic        leaf_wr;
      logic        res_load;
      status_type  res_status;
      res_src_type res_src;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic is_lookup;
      logic present;
      logic lvl_two;
      logic lvl_three;
      logic no_room;
      logic out_free;
   } stat_type;

endpackage

`default_nettype wire

// ----- design/four_level_page_table_mapper.sv -----
// Channel  Dir  Handshake            Fields (after the channel prefix)
// req      in   req_valid/req_stall  type, virt_page, phys_page, writable, user
// rsp      out  rsp_valid/rsp_stall  status, leaf_page, leaf_present, leaf_writable, leaf_user
//
// One request is worked on at a time. Its walk through the single-port table store (one
// read or one write a cycle), and any output stall, set the time between accepted transfers.
// An upper-level read uses READ and CHECK; each new table uses ALLOC; the leaf write LEAF.
// After reset the store is swept to zero, one entry a cycle, across all TABLE_COUNT * 512
// entries (32768 at the default size); requests are stalled until the sweep ends.
// A stalled result sits in the output register while the next request walks the table.
`default_nettype none

module four_level_page_table_mapper (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_type,
   input  wire logic [fltm_pkg::VP_W-1:0]   req_virt_page,
   input  wire logic [fltm_pkg::PAGE_W-1:0] req_phys_page,
   input  wire logic                        req_writable,
   input  wire logic                        req_user,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [fltm_pkg::STATUS_W-1:0]    rsp_status,
   output logic [fltm_pkg::PAGE_W-1:0]      rsp_leaf_page,
   output logic                             rsp_leaf_present,
   output logic                             rsp_leaf_writable,
   output logic                             rsp_leaf_user
);
   import fltm_pkg::*;

   // The controller sequences the walk: read and check each upper level, allocate the
   // missing tables in order, write or read the leaf, then hand the result over to the
   // output register. Tables are handed out by a bump counter and never reused, and the
   // whole store is zero after the sweep, so a freshly allocated table needs no clearing.
   cmd_type  cmd;
   stat_type st;

   fltm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   // The datapath holds the captured request, the walk position, the allocator, the
   // table store and the output register of the result channel.
   fltm_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .st                (st),
      .req_type          (req_type),
      .req_virt_page     (req_virt_page),
      .req_phys_page     (req_phys_page),
      .req_writable      (req_writable),
      .req_user          (req_user),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_leaf_page     (rsp_leaf_page),
      .rsp_leaf_present  (rsp_leaf_present),
      .rsp_leaf_writable (rsp_leaf_writable),
      .rsp_leaf_user     (rsp_leaf_user)
   );

endmodule

`default_nettype wire

// ----- design/fltm_ctrl.sv -----
`default_nettype none

module fltm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire fltm_pkg::stat_type st,
   output fltm_pkg::cmd_type       cmd
);
   import fltm_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            if (st.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_issue = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            priority if (st.lvl_three) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_OK;
               cmd.res_src    = SRC_READ;
               state_in       = ST_FINISH;
            end else if (st.present) begin
               cmd.follow = 1'b1;
               state_in   = (st.lvl_two && !st.is_lookup) ? ST_LEAF : ST_READ;
            end else if (st.is_lookup) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_NOT_MAPPED;
               cmd.res_src    = SRC_ZERO;
               state_in       = ST_FINISH;
            end else if (st.no_room) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = STATUS_NO_TABLES;
               cmd.res_src    = SRC_ZERO;
               state_in       = ST_FINISH;
            end else begin
               state_in = ST_ALLOC;
            end
         end
         ST_ALLOC: begin
            cmd.alloc = 1'b1;
            if (st.lvl_two) state_in = ST_LEAF;
         end
         ST_LEAF: begin
            cmd.leaf_wr    = 1'b1;
            cmd.res_load   = 1'b1;
            cmd.res_status = STATUS_OK;
            cmd.res_src    = SRC_LEAF;
            state_in       = ST_FINISH;
         end
         ST_FINISH: begin
            if (st.out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// ----- design/fltm_datapath.sv -----
`default_nettype none

module fltm_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire fltm_pkg::cmd_type             cmd,
   output fltm_pkg::stat_type                 st,
   input  wire logic                          req_type,
   input  wire logic [fltm_pkg::VP_W-1:0]     req_virt_page,
   input  wire logic [fltm_pkg::PAGE_W-1:0]   req_phys_page,
   input  wire logic                          req_writable,
   input  wire logic                          req_user,
   input  wire logic                          rsp_stall,
   output logic                               rsp_valid,
   output logic [fltm_pkg::STATUS_W-1:0]      rsp_status,
   output logic [fltm_pkg::PAGE_W-1:0]        rsp_leaf_page,
   output logic                               rsp_leaf_present,
   output logic                               rsp_leaf_writable,
   output logic                               rsp_leaf_user
);
   import fltm_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];

   req_kind_type       type_ff;
   logic [VP_W-1:0]    vp_ff;
   logic [PAGE_W-1:0]  pp_ff;
   logic               w_ff;
   logic               u_ff;
   logic [TBL_W-1:0]   table_ff;
   logic [LVL_W-1:0]   lvl_ff;
   logic [NF_W-1:0]    nf_ff;
   logic [ADDR_W-1:0]  clr_ff;
   logic [ENTRY_W-1:0] rd_ff;
   status_type         res_status_ff;
   logic [ENTRY_W-1:0] res_entry_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ENTRY_W-1:0] rsp_entry_ff;

   logic [IDX_W-1:0]   cur_idx;
   logic [TBL_W-1:0]   fresh;
   logic [ENTRY_W-1:0] leaf_entry;
   logic [ENTRY_W-1:0] alloc_entry;
   logic [ADDR_W-1:0]  mem_addr;
   logic               mem_we;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [NF_W:0]      need_sum;

   // The top index comes from the high bits of the page number.
   always_comb begin
      unique case (lvl_ff)
         2'd0:    cur_idx = vp_ff[4*IDX_W-1:3*IDX_W];
         2'd1:    cur_idx = vp_ff[3*IDX_W-1:2*IDX_W];
         2'd2:    cur_idx = vp_ff[2*IDX_W-1:IDX_W];
         default: cur_idx = vp_ff[IDX_W-1:0];
      endcase
   end

   assign fresh       = nf_ff[TBL_W-1:0];
   assign leaf_entry  = {u_ff, w_ff, 1'b1, pp_ff};
   assign alloc_entry = {3'b111, PAGE_W'(fresh)};
   assign mem_addr    = cmd.clear_wr ? clr_ff : {table_ff, cur_idx};
   assign mem_we      = cmd.clear_wr | cmd.alloc | cmd.leaf_wr;

   always_comb begin
      priority if (cmd.clear_wr) mem_wdata = '0;
      else if (cmd.alloc)        mem_wdata = alloc_entry;
      else                       mem_wdata = leaf_entry;
   end

   assign need_sum = {1'b0, nf_ff} + (NF_W + 1)'(2'd3 - lvl_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end else if (cmd.rd_issue) begin
         rd_ff <= mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nf_ff <= NF_W'(1);
      end else if (cmd.alloc) begin
         nf_ff <= nf_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff  <= req_kind_type'(req_type);
         vp_ff    <= req_virt_page;
         pp_ff    <= req_phys_page;
         w_ff     <= req_writable;
         u_ff     <= req_user;
         table_ff <= '0;
         lvl_ff   <= '0;
      end else if (cmd.follow) begin
         table_ff <= rd_ff[TBL_W-1:0];
         lvl_ff   <= lvl_ff + 1'b1;
      end else if (cmd.alloc) begin
         table_ff <= fresh;
         lvl_ff   <= lvl_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         unique case (cmd.res_src)
            SRC_READ: res_entry_ff <= rd_ff;
            SRC_LEAF: res_entry_ff <= leaf_entry;
            default:  res_entry_ff <= '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_entry_ff  <= res_entry_ff;
      end
   end

   assign st.clear_last = (clr_ff == ADDR_W'(DEPTH - 1));
   assign st.is_lookup  = (type_ff == REQ_LOOKUP);
   assign st.present    = rd_ff[BIT_PRESENT];
   assign st.lvl_two    = (lvl_ff == 2'd2);
   assign st.lvl_three  = (lvl_ff == 2'd3);
   assign st.no_room    = (need_sum > (NF_W + 1)'(TABLE_COUNT));
   assign st.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_leaf_page     = rsp_entry_ff[PAGE_W-1:0];
   assign rsp_leaf_present  = rsp_entry_ff[BIT_PRESENT];
   assign rsp_leaf_writable = rsp_entry_ff[BIT_WRITE];
   assign rsp_leaf_user     = rsp_entry_ff[BIT_USER];

   a_alloc_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc |-> (nf_ff < NF_W'(TABLE_COUNT)))
      else $error("table allocated beyond the store");

   a_free_count_moves_on_alloc: assert property (@(posedge clock) disable iff (reset)
      !cmd.alloc |=> $stable(nf_ff))
      else $error("free table count changed without an allocation");

   a_leaf_write_level: assert property (@(posedge clock) disable iff (reset)
      cmd.leaf_wr |-> (lvl_ff == 2'd3))
      else $error("leaf written above the last level");

   a_leaf_read_level: assert property (@(posedge clock) disable iff (reset)
      (cmd.res_load && (cmd.res_src == SRC_READ)) |-> (lvl_ff == 2'd3))
      else $error("lookup reported an upper-level entry as the leaf");

endmodule

`default_nettype wire

// ----- bench/four_level_page_table_mapper_test.sv -----
`timescale 1ns / 100ps

// Self-checking bench for the four-level page table mapper.
//
// Each request transfer that the block accepts is run through a shadow copy of the
// page table that lives in this module. The copy yields the one result that the
// request must produce; the bench queues it, or a directed row's written-in result,
// and checks it against the next result transfer. Both channels idle at random. The
// receiver holds off once for a long stretch, so the block backs up and stalls its
// request channel. The sender also stops once until every queued result is returned.
module four_level_page_table_mapper_test;
   import fltm_pkg::*;

   localparam int RANDOM_ITEMS    = 500;
   localparam int EXHAUST_MAPS    = 24;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int HOLD_OFF_AT     = 120;
   localparam int TAIL_CYCLES     = 40;

   typedef struct packed {
      req_kind_type      kind;
      logic [VP_W-1:0]   virt_page;
      logic [PAGE_W-1:0] phys_page;
      logic              writable;
      logic              user;
   } page_req_type;

   typedef struct packed {
      status_type        status;
      logic [PAGE_W-1:0] page;
      logic              present;
      logic              writable;
      logic              user;
   } leaf_rsp_type;

   // A row of the directed table. When known is set, the result is written into the row.
   // Otherwise the shadow table supplies it.
   typedef struct packed {
      page_req_type req;
      bit           known;
      leaf_rsp_type leaf;
   } stim_row_type;

   logic                clock             = 1'b0;
   logic                reset             = 1'b1;
   logic                req_valid         = 1'b0;
   logic                req_type          = REQ_MAP;
   logic [VP_W-1:0]     req_virt_page     = '0;
   logic [PAGE_W-1:0]   req_phys_page     = '0;
   logic                req_writable      = 1'b0;
   logic                req_user          = 1'b0;
   logic                rsp_stall         = 1'b0;
   logic                req_stall;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [PAGE_W-1:0]   rsp_leaf_page;
   logic                rsp_leaf_present;
   logic                rsp_leaf_writable;
   logic                rsp_leaf_user;

   four_level_page_table_mapper u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_virt_page     (req_virt_page),
      .req_phys_page     (req_phys_page),
      .req_writable      (req_writable),
      .req_user          (req_user),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_leaf_page     (rsp_leaf_page),
      .rsp_leaf_present  (rsp_leaf_present),
      .rsp_leaf_writable (rsp_leaf_writable),
      .rsp_leaf_user     (rsp_leaf_user)
   );

   // Shadow page table and bump allocator. They are kept in step with the block, one
   // accepted request at a time.
   logic [ENTRY_W-1:0] shadow_store [DEPTH];
   int                 shadow_next_free;

   leaf_rsp_type       expected_leaves [$];
   logic [VP_W-1:0]    mapped_pages [$];
   stim_row_type       directed_rows [$];
   int                 mismatches   = 0;
   int                 results_seen = 0;
   bit                 sender_steady = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // The run is ended here if it hangs. The bound leaves plenty of margin over the
   // clearing sweep and the slowest correct run.
   initial begin
      #5_000_000;
      $display("** four_level_page_table_mapper: FAILED **");
      $finish;
   end

   // Most gaps are short; about one in ten is long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic leaf_rsp_type entry_to_leaf(status_type st, logic [ENTRY_W-1:0] e);
      leaf_rsp_type l;
      l.status   = st;
      l.page     = e[PAGE_W-1:0];
      l.present  = e[BIT_PRESENT];
      l.writable = e[BIT_WRITE];
      l.user     = e[BIT_USER];
      return l;
   endfunction

   // Walks the shadow table for one request, applies any map to it and returns the
   // result that the block should send back.
   task automatic walk_page_table(input page_req_type rq, output leaf_rsp_type rs);
      logic [IDX_W-1:0]   idx [4];
      logic [ENTRY_W-1:0] e;
      int                 tbl;
      int                 lvl;
      int                 fresh;
      bit                 walking;
      idx[0]  = rq.virt_page[35:27];
      idx[1]  = rq.virt_page[26:18];
      idx[2]  = rq.virt_page[17:9];
      idx[3]  = rq.virt_page[8:0];
      tbl     = 0;
      lvl     = 0;
      walking = 1'b1;
      // Follow the upper levels for as long as their entries are present.
      while (walking && lvl < 3) begin
         e = shadow_store[tbl * ENTRIES_PER_TABLE + idx[lvl]];
         if (!e[BIT_PRESENT]) begin
            walking = 1'b0;
         end else begin
            tbl = int'(e[PAGE_W-1:0] % TABLE_COUNT);
            lvl++;
         end
      end
      if (rq.kind == REQ_LOOKUP) begin
         if (lvl < 3)
            rs = entry_to_leaf(STATUS_NOT_MAPPED, '0);
         else
            rs = entry_to_leaf(STATUS_OK, shadow_store[tbl * ENTRIES_PER_TABLE + idx[3]]);
      end else if (shadow_next_free + (3 - lvl) > TABLE_COUNT) begin
         // Too few tables remain. The map is refused whole, and nothing is allocated.
         rs = entry_to_leaf(STATUS_NO_TABLES, '0);
      end else begin
         while (lvl < 3) begin
            fresh = shadow_next_free % TABLE_COUNT;
            shadow_next_free++;
            for (int k = 0; k < ENTRIES_PER_TABLE; k++)
               shadow_store[fresh * ENTRIES_PER_TABLE + k] = '0;
            e = '0;
            e[PAGE_W-1:0]  = PAGE_W'(fresh);
            e[BIT_PRESENT] = 1'b1;
            e[BIT_WRITE]   = 1'b1;
            e[BIT_USER]    = 1'b1;
            shadow_store[tbl * ENTRIES_PER_TABLE + idx[lvl]] = e;
            tbl = fresh;
            lvl++;
         end
         e = '0;
         e[PAGE_W-1:0]  = rq.phys_page;
         e[BIT_PRESENT] = 1'b1;
         e[BIT_WRITE]   = rq.writable;
         e[BIT_USER]    = rq.user;
         shadow_store[tbl * ENTRIES_PER_TABLE + idx[3]] = e;
         rs = entry_to_leaf(STATUS_OK, e);
      end
   endtask

   task automatic add_row(input req_kind_type kind, input logic [VP_W-1:0] vp,
                          input logic [PAGE_W-1:0] pp, input logic w, input logic u,
                          input bit known, input status_type st,
                          input logic [PAGE_W-1:0] page, input logic p, input logic wr,
                          input logic us);
      stim_row_type row;
      row.req.kind      = kind;
      row.req.virt_page = vp;
      row.req.phys_page = pp;
      row.req.writable  = w;
      row.req.user      = u;
      row.known         = known;
      row.leaf.status   = st;
      row.leaf.page     = page;
      row.leaf.present  = p;
      row.leaf.writable = wr;
      row.leaf.user     = us;
      directed_rows.push_back(row);
   endtask

   // Indices come mostly from a small pool, so that random requests share upper
   // tables and reach leaves that are already mapped. Now and then a fresh index
   // opens a new path and uses up tables.
   function automatic logic [IDX_W-1:0] pick_index(int lvl);
      int fresh_pct;
      fresh_pct = (lvl == 0) ? 12 : (lvl == 1) ? 20 : (lvl == 2) ? 30 : 50;
      if ($urandom_range(0, 99) < fresh_pct)
         return IDX_W'($urandom_range(0, ENTRIES_PER_TABLE - 1));
      unique case ($urandom_range(0, 3))
         0:       return 9'd0;
         1:       return 9'd1;
         2:       return 9'd511;
         default: return 9'd256;
      endcase
   endfunction

   function automatic logic [VP_W-1:0] build_virt_page();
      return {pick_index(0), pick_index(1), pick_index(2), pick_index(3)};
   endfunction

   function automatic logic [PAGE_W-1:0] random_page();
      logic [63:0] wide;
      wide = {$urandom(), $urandom()};
      return wide[PAGE_W-1:0];
   endfunction

   // Maps, with some remaps, make up about half of the requests. Most lookups go to
   // pages that were mapped before. The remainder go to random paths, which mostly
   // miss.
   task automatic make_random_request(output page_req_type rq);
      int r;
      r            = $urandom_range(0, 99);
      rq.phys_page = random_page();
      rq.writable  = 1'($urandom_range(0, 1));
      rq.user      = 1'($urandom_range(0, 1));
      if (r < 45) begin
         rq.kind = REQ_MAP;
         if (mapped_pages.size() > 0 && $urandom_range(0, 4) == 0)
            rq.virt_page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
         else
            rq.virt_page = build_virt_page();
         mapped_pages.push_back(rq.virt_page);
      end else if (r < 80 && mapped_pages.size() > 0) begin
         rq.kind      = REQ_LOOKUP;
         rq.virt_page = mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      end else begin
         rq.kind      = REQ_LOOKUP;
         rq.virt_page = build_virt_page();
      end
   endtask

   // Called at a falling edge. The task offers the request until a transfer takes it
   // and then records the expected result. It then either drops valid for a gap or
   // leaves valid high, so that the caller can offer the next request in the same step.
   task automatic offer_request(input page_req_type rq, input bit known,
                                input leaf_rsp_type known_leaf);
      leaf_rsp_type predicted;
      int           gap;
      req_valid     <= 1'b1;
      req_type      <= rq.kind;
      req_virt_page <= rq.virt_page;
      req_phys_page <= rq.phys_page;
      req_writable  <= rq.writable;
      req_user      <= rq.user;
      do
         @(posedge clock);
      while (req_stall);
      walk_page_table(rq, predicted);
      expected_leaves.push_back(known ? known_leaf : predicted);
      @(negedge clock);
      gap = sender_steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Sender: reset, the directed table, random traffic and a closing run of maps
   // that exhausts the allocator, followed by lookups.
   initial begin
      page_req_type rq;
      for (int k = 0; k < DEPTH; k++)
         shadow_store[k] = '0;
      shadow_next_free = 1;

      // Rows with a written-in result are the cases whose result is obvious. The other
      // rows take their result from the shadow table.
      // Lookups of a table that has only just been cleared find no upper levels.
      add_row(REQ_LOOKUP, '0, '0, 0, 0, 1, STATUS_NOT_MAPPED, '0, 0, 0, 0);
      add_row(REQ_LOOKUP, '1, '1, 1, 1, 1, STATUS_NOT_MAPPED, '0, 0, 0, 0);
      // Extremes of the page fields, with a full walk allocated for each.
      add_row(REQ_MAP,    '0, '0, 0, 0, 1, STATUS_OK, '0, 1, 0, 0);
      add_row(REQ_LOOKUP, '0, '1, 1, 1, 1, STATUS_OK, '0, 1, 0, 0);
      add_row(REQ_MAP,    '1, '1, 1, 1, 1, STATUS_OK, '1, 1, 1, 1);
      add_row(REQ_LOOKUP, '1, '0, 0, 0, 1, STATUS_OK, '1, 1, 1, 1);
      // The leaf table exists, but this leaf has never been written.
      add_row(REQ_LOOKUP, 36'd1, '0, 0, 0, 1, STATUS_OK, '0, 0, 0, 0);
      // A remap overwrites the leaf in place.
      add_row(REQ_MAP,    '0, 40'h55_5555_5555, 1, 0, 1, STATUS_OK, 40'h55_5555_5555, 1, 1, 0);
      add_row(REQ_LOOKUP, '0, '0, 0, 0, 1, STATUS_OK, 40'h55_5555_5555, 1, 1, 0);
      // A second level is missing below an existing root entry.
      add_row(REQ_LOOKUP, {9'd0, 9'd1, 9'd0, 9'd0}, '0, 0, 0, 1,
              STATUS_NOT_MAPPED, '0, 0, 0, 0);
      add_row(REQ_MAP, {9'd0, 9'd1, 9'd0, 9'd0}, 40'hAA_AAAA_AAAA, 0, 1, 1,
              STATUS_OK, 40'hAA_AAAA_AAAA, 1, 0, 1);
      add_row(REQ_LOOKUP, {9'd0, 9'd1, 9'd0, 9'd0}, '0, 0, 0, 1,
              STATUS_OK, 40'hAA_AAAA_AAAA, 1, 0, 1);
      // A map that needs only a new leaf table.
      add_row(REQ_MAP, {9'd0, 9'd0, 9'd1, 9'd5}, 40'h12_3456_789A, 1, 1, 0,
              STATUS_OK, '0, 0, 0, 0);
      add_row(REQ_LOOKUP, {9'd0, 9'd0, 9'd1, 9'd5}, '0, 0, 0, 0,
              STATUS_OK, '0, 0, 0, 0);
      // A map that shares the whole walk of the top page.
      add_row(REQ_MAP, {9'd511, 9'd511, 9'd511, 9'd0}, 40'd1, 0, 1, 0,
              STATUS_OK, '0, 0, 0, 0);
      add_row(REQ_LOOKUP, {9'd511, 9'd511, 9'd511, 9'd0}, '0, 0, 0, 0,
              STATUS_OK, '0, 0, 0, 0);
      add_row(REQ_LOOKUP, {9'd511, 9'd0, 9'd0, 9'd0}, '0, 0, 0, 1,
              STATUS_NOT_MAPPED, '0, 0, 0, 0);
      add_row(REQ_MAP, {9'd2, 9'd3, 9'd4, 9'd5}, 40'h80_0000_0000, 1, 1, 0,
              STATUS_OK, '0, 0, 0, 0);
      add_row(REQ_LOOKUP, {9'd2, 9'd3, 9'd4, 9'd5}, '0, 0, 0, 0,
              STATUS_OK, '0, 0, 0, 0);
      add_row(REQ_MAP, {9'd0, 9'd0, 9'd0, 9'd511}, 40'h7F_FFFF_FFFF, 0, 0, 0,
              STATUS_OK, '0, 0, 0, 0);
      add_row(REQ_LOOKUP, {9'd0, 9'd0, 9'd0, 9'd511}, '0, 0, 0, 0,
              STATUS_OK, '0, 0, 0, 0);
      add_row(REQ_LOOKUP, '1, '0, 0, 0, 1, STATUS_OK, '1, 1, 1, 1);

      // Reset is held from the start and released at a falling edge. The block then
      // sweeps its store to zero and keeps req_stall high meanwhile. The first request
      // simply waits for the sweep to end.
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         offer_request(directed_rows[i].req, directed_rows[i].known, directed_rows[i].leaf);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 250) begin
            // Stop offering and let the block drain, so that it runs from empty again.
            req_valid <= 1'b0;
            @(negedge clock);
            while (expected_leaves.size() != 0)
               @(negedge clock);
         end
         sender_steady = (n >= 350 && n < 420);
         make_random_request(rq);
         offer_request(rq, 1'b0, '0);
      end
      sender_steady = 1'b0;

      // Each map uses a root index of its own, so this run uses up the allocator. The later
      // maps are refused for lack of tables. The lookups then check that those
      // refused maps left no trace.
      for (int k = 0; k < EXHAUST_MAPS; k++) begin
         rq.kind      = REQ_MAP;
         rq.virt_page = {9'(300 + k), 27'($urandom())};
         rq.phys_page = random_page();
         rq.writable  = 1'($urandom_range(0, 1));
         rq.user      = 1'($urandom_range(0, 1));
         mapped_pages.push_back(rq.virt_page);
         offer_request(rq, 1'b0, '0);
      end
      for (int k = 0; k < 6; k++) begin
         rq.kind      = REQ_LOOKUP;
         rq.virt_page = mapped_pages[mapped_pages.size() - 1 - 4 * k];
         offer_request(rq, 1'b0, '0);
      end

      req_valid <= 1'b0;
      @(negedge clock);
      while (expected_leaves.size() != 0)
         @(posedge clock);
      // Keep the receiver running past the drain, so that a stray result still shows up.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("** four_level_page_table_mapper: PASSED **");
      else
         $display("** four_level_page_table_mapper: FAILED **");
      $finish;
   end

   // Receiver: stall is decided at the falling edge and a result transfer is checked at
   // the rising edge. Once, at a fixed result count, stall is held high for a long run.
   // For a stretch of results it is never raised.
   initial begin
      int           stall_left;
      bit           hold_done;
      leaf_rsp_type want;
      stall_left = 0;
      hold_done  = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && results_seen == HOLD_OFF_AT) begin
            stall_left = HOLD_OFF_CYCLES;
            hold_done  = 1'b1;
         end else if (stall_left == 0 && !(results_seen >= 200 && results_seen < 280)
                      && $urandom_range(0, 99) < 30) begin
            stall_left = pick_gap();
         end
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0)
            stall_left--;
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_leaves.size() == 0) begin
               $error("result transfer with no request outstanding");
               mismatches++;
            end else begin
               want = expected_leaves.pop_front();
               if (rsp_status !== want.status) begin
                  $error("rsp_status: expected %0d, got %0d", want.status, rsp_status);
                  mismatches++;
               end
               if (rsp_leaf_page !== want.page) begin
                  $error("rsp_leaf_page: expected %h, got %h", want.page, rsp_leaf_page);
                  mismatches++;
               end
               if (rsp_leaf_present !== want.present) begin
                  $error("rsp_leaf_present: expected %b, got %b",
                         want.present, rsp_leaf_present);
                  mismatches++;
               end
               if (rsp_leaf_writable !== want.writable) begin
                  $error("rsp_leaf_writable: expected %b, got %b",
                         want.writable, rsp_leaf_writable);
                  mismatches++;
               end
               if (rsp_leaf_user !== want.user) begin
                  $error("rsp_leaf_user: expected %b, got %b", want.user, rsp_leaf_user);
                  mismatches++;
               end
            end
         end
      end
   end

endmodule
